[rtl/sht_pkg.sv]
// Shared types, constants and the sequencer microprogram for the sensor measurement controller.
package sht_pkg;

   // Configuration port
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_STARTUP = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POLL    = 1'd1;

   localparam logic [CFG_W-1:0] STARTUP_RESET = 16'd11;
   localparam logic [CFG_W-1:0] POLL_RESET    = 16'd10;

   // Bits read per sensor word, including the byte that gets the host acknowledge
   localparam logic [4:0] READ_BITS = 5'd16;
   localparam logic [4:0] HACK_BIT  = 5'd8;

   // Sequencer
   localparam int STEP_W = 6;
   localparam int CNT_W  = 5;
   localparam int WORD_W = 16;

   localparam logic [STEP_W-1:0] ST_IDLE    = 6'd0;
   localparam logic [STEP_W-1:0] ST_STARTUP = 6'd1;
   localparam logic [STEP_W-1:0] ST_RESET   = 6'd2;
   localparam logic [STEP_W-1:0] ST_TSTART  = 6'd3;
   localparam logic [STEP_W-1:0] ST_CMD     = 6'd4;
   localparam logic [STEP_W-1:0] ST_ACK     = 6'd5;
   localparam logic [STEP_W-1:0] ST_POLL    = 6'd6;
   localparam logic [STEP_W-1:0] ST_RDLO    = 6'd7;
   localparam logic [STEP_W-1:0] ST_RDHI    = 6'd8;
   localparam logic [STEP_W-1:0] ST_HACKA   = 6'd9;
   localparam logic [STEP_W-1:0] ST_HACKB   = 6'd10;
   localparam logic [STEP_W-1:0] ST_RDEND   = 6'd11;
   localparam logic [STEP_W-1:0] ST_CONV    = 6'd12;
   localparam logic [STEP_W-1:0] ST_ROUND   = 6'd28;

   // Pin patterns: transmission start, indexed by tick within the pattern
   localparam logic [7:0] TS_SCK  = 8'b0011_0110;
   localparam logic [7:0] TS_PULL = 8'b0001_1100;

   localparam logic [7:0] CMD_TEMP = 8'h03;
   localparam logic [7:0] CMD_HUM  = 8'h05;

   // Conversion arithmetic, 40 fraction bits
   localparam int ACC_W   = 62;
   localparam int FRAC_W  = 40;
   localparam int X_W     = 34;
   localparam int B_W     = 17;
   localparam int PROD_W  = X_W + B_W;
   localparam int K_W     = 48;
   localparam int CHUNK_W = 16;
   localparam int RR_W    = 32;
   localparam int RS_W    = 33;
   localparam int TEMP_W  = 17;
   localparam int HUM_W   = 16;
   localparam int HROUND_W = ACC_W - FRAC_W;

   localparam logic signed [ACC_W-1:0] Q_C0  = -62'sd225048039973192;
   localparam logic signed [K_W-1:0]   Q_C1  = 48'sd4035207673938;
   localparam logic signed [K_W-1:0]   Q_NC2 = -48'sd175427080;
   localparam logic signed [K_W-1:0]   Q_D0  = 48'sd10995116278;
   localparam logic signed [K_W-1:0]   Q_D1  = 48'sd87960930;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = 62'sd549755813888;

   localparam logic signed [TEMP_W-1:0] TEMP_OFS = 17'sd3965;
   localparam logic signed [TEMP_W-1:0] SLOPE_OFS = 17'sd6465;

   localparam logic signed [HROUND_W-1:0] HUM_MAX = 22'sd32767;
   localparam logic signed [HROUND_W-1:0] HUM_MIN = -22'sd32768;

   typedef enum logic [2:0] {
      SCK_LO, SCK_HI, SCK_RST, SCK_TS, SCK_CMD, SCK_ACK
   } sck_sel_type;

   typedef enum logic [1:0] {
      PULL_OFF, PULL_ON, PULL_TS, PULL_CMD
   } pull_sel_type;

   typedef enum logic [3:0] {
      BR_NEXT, BR_JUMP, BR_START, BR_WAIT, BR_COUNT,
      BR_ACK, BR_POLL, BR_SHIFT, BR_READ, BR_HUM
   } br_type;

   typedef enum logic [1:0] {
      GO_HOLD, GO_NEXT, GO_A, GO_B
   } go_type;

   typedef enum logic [1:0] {
      X_R, X_S, X_RR, X_RS
   } xsel_type;

   typedef enum logic {
      B_R, B_K
   } bsel_type;

   typedef enum logic [1:0] {
      K_C1, K_NC2, K_D0, K_D1
   } kconst_type;

   typedef enum logic [1:0] {
      MD_NONE, MD_P, MD_RR, MD_RS
   } mdest_type;

   typedef struct packed {
      logic       init;
      logic       add;
      mdest_type  dest;
      xsel_type   x_sel;
      bsel_type   b_sel;
      kconst_type kconst;
      logic [1:0] pos;
   } mac_ctl_type;

   typedef struct packed {
      logic              wait_item;
      sck_sel_type       sck_sel;
      pull_sel_type      pull_sel;
      br_type            br;
      logic [CNT_W-1:0]  limit;
      logic [STEP_W-1:0] jump_a;
      logic [STEP_W-1:0] jump_b;
      logic              done_a;
      logic              defer_a;
      mac_ctl_type       mac;
   } ctl_type;

   // One 17-bit signed slice of a 48-bit coefficient; the top slice carries the sign
   function automatic logic signed [B_W-1:0] k_chunk(kconst_type k, logic [1:0] pos);
      logic signed [K_W-1:0] kv;
      logic [CHUNK_W-1:0]    c;
      case (k)
         K_C1:    kv = Q_C1;
         K_NC2:   kv = Q_NC2;
         K_D0:    kv = Q_D0;
         K_D1:    kv = Q_D1;
         default: kv = Q_C1;
      endcase
      case (pos)
         2'd0:    c = kv[CHUNK_W-1:0];
         2'd1:    c = kv[2*CHUNK_W-1:CHUNK_W];
         default: c = kv[3*CHUNK_W-1:2*CHUNK_W];
      endcase
      if (pos == 2'd0 || pos == 2'd1) begin
         return signed'({1'b0, c});
      end
      return signed'({c[CHUNK_W-1], c});
   endfunction

   function automatic mac_ctl_type mac_mul(xsel_type x, bsel_type b, kconst_type k,
                                           logic [1:0] pos, mdest_type d, logic add);
      mac_ctl_type m;
      m        = '0;
      m.x_sel  = x;
      m.b_sel  = b;
      m.kconst = k;
      m.pos    = pos;
      m.dest   = d;
      m.add    = add;
      return m;
   endfunction

   // Microprogram ROM
   function automatic ctl_type ucode(logic [STEP_W-1:0] step);
      ctl_type c;
      c           = '0;
      c.wait_item = 1'b0;
      c.br        = BR_NEXT;
      case (step)
         ST_IDLE: begin
            c.wait_item = 1'b1;
            c.br        = BR_START;
            c.jump_a    = ST_STARTUP;
         end
         ST_STARTUP: begin
            c.wait_item = 1'b1;
            c.br        = BR_WAIT;
            c.jump_a    = ST_RESET;
         end
         ST_RESET: begin
            c.wait_item = 1'b1;
            c.sck_sel   = SCK_RST;
            c.br        = BR_COUNT;
            c.limit     = 5'd17;
            c.jump_a    = ST_TSTART;
         end
         ST_TSTART: begin
            c.wait_item = 1'b1;
            c.sck_sel   = SCK_TS;
            c.pull_sel  = PULL_TS;
            c.br        = BR_COUNT;
            c.limit     = 5'd6;
            c.jump_a    = ST_CMD;
         end
         ST_CMD: begin
            c.wait_item = 1'b1;
            c.sck_sel   = SCK_CMD;
            c.pull_sel  = PULL_CMD;
            c.br        = BR_COUNT;
            c.limit     = 5'd15;
            c.jump_a    = ST_ACK;
         end
         ST_ACK: begin
            c.wait_item = 1'b1;
            c.sck_sel   = SCK_ACK;
            c.br        = BR_ACK;
            c.jump_a    = ST_IDLE;
            c.done_a    = 1'b1;
         end
         ST_POLL: begin
            c.wait_item = 1'b1;
            c.br        = BR_POLL;
         end
         ST_RDLO: begin
            c.wait_item = 1'b1;
            c.br        = BR_SHIFT;
         end
         ST_RDHI: begin
            c.wait_item = 1'b1;
            c.sck_sel   = SCK_HI;
            c.br        = BR_READ;
            c.jump_a    = ST_RDEND;
            c.jump_b    = ST_RDLO;
         end
         ST_HACKA: begin
            c.wait_item = 1'b1;
            c.pull_sel  = PULL_ON;
         end
         ST_HACKB: begin
            c.wait_item = 1'b1;
            c.sck_sel   = SCK_HI;
            c.pull_sel  = PULL_ON;
            c.br        = BR_JUMP;
            c.jump_a    = ST_RDLO;
         end
         ST_RDEND: begin
            c.wait_item = 1'b1;
            c.br        = BR_HUM;
            c.jump_a    = ST_CONV;
            c.jump_b    = ST_TSTART;
            c.defer_a   = 1'b1;
         end
         ST_CONV:          c.mac.init = 1'b1;
         ST_CONV + 6'd1:   c.mac = mac_mul(X_R,  B_K, K_C1,  2'd0, MD_P,  1'b0);
         ST_CONV + 6'd2:   c.mac = mac_mul(X_R,  B_K, K_C1,  2'd1, MD_P,  1'b1);
         ST_CONV + 6'd3:   c.mac = mac_mul(X_R,  B_K, K_C1,  2'd2, MD_P,  1'b1);
         ST_CONV + 6'd4:   c.mac = mac_mul(X_R,  B_R, K_C1,  2'd0, MD_RR, 1'b1);
         ST_CONV + 6'd5:   c.mac = mac_mul(X_RR, B_K, K_NC2, 2'd0, MD_P,  1'b0);
         ST_CONV + 6'd6:   c.mac = mac_mul(X_RR, B_K, K_NC2, 2'd1, MD_P,  1'b1);
         ST_CONV + 6'd7:   c.mac = mac_mul(X_RR, B_K, K_NC2, 2'd2, MD_P,  1'b1);
         ST_CONV + 6'd8:   c.mac = mac_mul(X_S,  B_K, K_D0,  2'd0, MD_P,  1'b1);
         ST_CONV + 6'd9:   c.mac = mac_mul(X_S,  B_K, K_D0,  2'd1, MD_P,  1'b1);
         ST_CONV + 6'd10:  c.mac = mac_mul(X_S,  B_K, K_D0,  2'd2, MD_P,  1'b1);
         ST_CONV + 6'd11:  c.mac = mac_mul(X_S,  B_R, K_C1,  2'd0, MD_RS, 1'b1);
         ST_CONV + 6'd12:  c.mac = mac_mul(X_RS, B_K, K_D1,  2'd0, MD_P,  1'b0);
         ST_CONV + 6'd13:  c.mac = mac_mul(X_RS, B_K, K_D1,  2'd1, MD_P,  1'b1);
         ST_CONV + 6'd14:  c.mac = mac_mul(X_RS, B_K, K_D1,  2'd2, MD_P,  1'b1);
         ST_CONV + 6'd15:  c.mac = mac_mul(X_R,  B_R, K_C1,  2'd0, MD_NONE, 1'b1);
         ST_ROUND: begin
            c.br     = BR_JUMP;
            c.jump_a = ST_IDLE;
            c.done_a = 1'b1;
         end
         default: begin
            c.wait_item = 1'b1;
            c.br        = BR_JUMP;
            c.jump_a    = ST_IDLE;
         end
      endcase
      return c;
   endfunction

endpackage

[rtl/sht1x_measure_controller.sv]
// Top level: microcoded pin sequencer, result register and configuration registers.
//
//   channel  | ports                                   | item
//   ---------+-----------------------------------------+--------------------------------
//   req      | req_valid, req_stall, req_start_req,    | one pin tick in
//            | req_data_in                             |
//   rsp      | rsp_valid, rsp_stall, rsp_sck_level ... | pin levels, status, results
//   csr      | csr_we, csr_index, csr_wdata            | startup wait, poll interval
//
// One tick item per cycle while req_stall is low; each item gives one result through a registered output.
// The tick that ends the humidity read starts the conversion: 17 microsteps on one
// shared 34x17 multiplier, and that item's result is given by the last microstep.
// Synchronous active-high reset returns the sequencer to idle and the registers to 11 and 10.
// req_stall is high while the conversion runs and while an unread result is stalled.
module sht1x_measure_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_start_req,
   input  logic                                req_data_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_sck_level,
   output logic                                rsp_data_pull_low,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic                                rsp_ack_error,
   output logic [sht_pkg::WORD_W-1:0]          rsp_raw_temperature,
   output logic [sht_pkg::WORD_W-1:0]          rsp_raw_humidity,
   output logic signed [sht_pkg::TEMP_W-1:0]   rsp_temperature_centi,
   output logic signed [sht_pkg::HUM_W-1:0]    rsp_humidity_centi,
   input  logic                                csr_we,
   input  logic [sht_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sht_pkg::CFG_W-1:0]           csr_wdata
);
   import sht_pkg::*;

   // configuration
   logic [CFG_W-1:0]  startup_ff, startup_in;
   logic [CFG_W-1:0]  poll_ff, poll_in;

   // sequencer state
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  bc_ff, bc_in;
   logic [WORD_W-1:0] shift_ff, shift_in;
   logic [WORD_W-1:0] held_ff, held_in;
   logic [WORD_W-1:0] wait_ff, wait_in;
   logic              hum_ff, hum_in;
   logic              err_ff, err_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     sck_ff, sck_in;
   logic                     pull_ff, pull_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic                     aerr_ff;
   logic [WORD_W-1:0]        rawt_ff, rawt_in;
   logic [WORD_W-1:0]        rawh_ff, rawh_in;
   logic signed [TEMP_W-1:0] tc_ff, tc_in;
   logic signed [HUM_W-1:0]  hc_ff, hc_in;

   ctl_type                  ctl;
   go_type                   go;
   logic                     rsp_free;
   logic                     accept;
   logic                     step_go;
   logic                     emit;
   logic [7:0]               cmd_byte;
   logic                     cmd_bit;
   logic signed [HUM_W-1:0]  humidity;
   logic signed [TEMP_W-1:0] temp_centi;

   assign ctl      = ucode(step_ff);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !ctl.wait_item || !rsp_free;
   assign accept   = req_valid && !req_stall;
   // conversion steps run free; the last one waits for room in the result register
   assign step_go  = ctl.wait_item ? accept : (!ctl.done_a || rsp_free);

   sht_mac u_mac (
      .clock    (clock),
      .mac_ctl  (ctl.mac),
      .raw_temp (held_ff),
      .raw_hum  (shift_ff),
      .humidity (humidity)
   );

   assign temp_centi = signed'({1'b0, held_ff}) - TEMP_OFS;
   assign cmd_byte   = hum_ff ? CMD_HUM : CMD_TEMP;
   assign cmd_bit    = cmd_byte[~bc_ff[3:1]];

   // branch decision and counter updates
   always_comb begin
      go       = GO_HOLD;
      bc_in    = bc_ff;
      shift_in = shift_ff;
      held_in  = held_ff;
      wait_in  = wait_ff;
      hum_in   = hum_ff;
      err_in   = err_ff;
      case (ctl.br)
         BR_NEXT: go = GO_NEXT;
         BR_JUMP: go = GO_A;
         BR_START: begin
            if (req_start_req) begin
               go      = GO_A;
               wait_in = startup_ff;
               err_in  = 1'b0;
               hum_in  = 1'b0;
               held_in = '0;
               bc_in   = '0;
            end
         end
         BR_WAIT: begin
            if (wait_ff == '0) begin
               go    = GO_A;
               bc_in = '0;
            end else begin
               wait_in = wait_ff - 16'd1;
            end
         end
         BR_COUNT: begin
            if (bc_ff >= ctl.limit) begin
               go    = GO_A;
               bc_in = '0;
            end else begin
               bc_in = bc_ff + 5'd1;
            end
         end
         BR_ACK: begin
            // idle tick, clock high with sample, release tick
            if (bc_ff == 5'd1) begin
               err_in = err_ff | req_data_in;
               bc_in  = 5'd2;
            end else if (bc_ff == 5'd0) begin
               bc_in = 5'd1;
            end else begin
               bc_in = '0;
               if (err_ff) begin
                  go = GO_A;
               end else begin
                  go      = GO_NEXT;
                  wait_in = '0;
               end
            end
         end
         BR_POLL: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - 16'd1;
            end else if (!req_data_in) begin
               go       = GO_NEXT;
               bc_in    = '0;
               shift_in = '0;
            end else begin
               wait_in = (poll_ff == '0) ? '0 : poll_ff - 16'd1;
            end
         end
         BR_SHIFT: begin
            go       = GO_NEXT;
            shift_in = {shift_ff[WORD_W-2:0], req_data_in};
            bc_in    = bc_ff + 5'd1;
         end
         BR_READ: begin
            if (bc_ff >= READ_BITS) begin
               go = GO_A;
            end else if (bc_ff == HACK_BIT) begin
               go = GO_NEXT;
            end else begin
               go = GO_B;
            end
         end
         BR_HUM: begin
            bc_in = '0;
            if (hum_ff) begin
               go = GO_A;
            end else begin
               go      = GO_B;
               held_in = shift_ff;
               hum_in  = 1'b1;
            end
         end
         default: go = GO_A;
      endcase

      case (go)
         GO_HOLD: step_in = step_ff;
         GO_NEXT: step_in = step_ff + 6'd1;
         GO_A:    step_in = ctl.jump_a;
         GO_B:    step_in = ctl.jump_b;
         default: step_in = step_ff;
      endcase
   end

   // pin levels and result fields
   always_comb begin
      case (ctl.sck_sel)
         SCK_LO:  sck_in = 1'b0;
         SCK_HI:  sck_in = 1'b1;
         SCK_RST: sck_in = ~bc_ff[0];
         SCK_TS:  sck_in = TS_SCK[bc_ff[2:0]];
         SCK_CMD: sck_in = bc_ff[0];
         SCK_ACK: sck_in = (bc_ff == 5'd1);
         default: sck_in = 1'b0;
      endcase
      case (ctl.pull_sel)
         PULL_OFF: pull_in = 1'b0;
         PULL_ON:  pull_in = 1'b1;
         PULL_TS:  pull_in = TS_PULL[bc_ff[2:0]];
         PULL_CMD: pull_in = ~cmd_bit;
         default:  pull_in = 1'b0;
      endcase
      busy_in = (step_in != ST_IDLE);
      done_in = ctl.done_a && (go == GO_A);
      // only the conversion's last step carries the measured fields
      if (!ctl.wait_item) begin
         rawt_in = held_ff;
         rawh_in = shift_ff;
         tc_in   = temp_centi;
         hc_in   = humidity;
      end else begin
         rawt_in = '0;
         rawh_in = '0;
         tc_in   = '0;
         hc_in   = '0;
      end
      // hold back the result of the tick that starts the conversion
      if (ctl.wait_item) begin
         emit = step_go && !(ctl.defer_a && (go == GO_A));
      end else begin
         emit = step_go && ctl.done_a;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_comb begin
      startup_in = startup_ff;
      poll_in    = poll_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_STARTUP: startup_in = csr_wdata;
            CSR_POLL:    poll_in    = csr_wdata;
            default:     ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         startup_ff   <= STARTUP_RESET;
         poll_ff      <= POLL_RESET;
         step_ff      <= ST_IDLE;
         bc_ff        <= '0;
         shift_ff     <= '0;
         held_ff      <= '0;
         wait_ff      <= '0;
         hum_ff       <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         startup_ff   <= startup_in;
         poll_ff      <= poll_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step_go) begin
            step_ff  <= step_in;
            bc_ff    <= bc_in;
            shift_ff <= shift_in;
            held_ff  <= held_in;
            wait_ff  <= wait_in;
            hum_ff   <= hum_in;
            err_ff   <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         sck_ff  <= sck_in;
         pull_ff <= pull_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
         aerr_ff <= err_in;
         rawt_ff <= rawt_in;
         rawh_ff <= rawh_in;
         tc_ff   <= tc_in;
         hc_ff   <= hc_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_sck_level         = sck_ff;
   assign rsp_data_pull_low     = pull_ff;
   assign rsp_busy_res          = busy_ff;
   assign rsp_done_res          = done_ff;
   assign rsp_ack_error         = aerr_ff;
   assign rsp_raw_temperature   = rawt_ff;
   assign rsp_raw_humidity      = rawh_ff;
   assign rsp_temperature_centi = tc_ff;
   assign rsp_humidity_centi    = hc_ff;

endmodule

[rtl/sht_mac.sv]
// Multiply-accumulate datapath for the humidity compensation, stepped by the microprogram.
module sht_mac (
   input  logic                                clock,
   input  sht_pkg::mac_ctl_type                mac_ctl,
   input  logic [sht_pkg::WORD_W-1:0]          raw_temp,
   input  logic [sht_pkg::WORD_W-1:0]          raw_hum,
   output logic signed [sht_pkg::HUM_W-1:0]    humidity
);
   import sht_pkg::*;

   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    acc_in;
   logic signed [PROD_W-1:0]   p_ff;
   logic [1:0]                 pos_ff;
   logic [RR_W-1:0]            rr_ff;
   logic signed [RS_W-1:0]     rs_ff;

   logic signed [TEMP_W-1:0]   slope;
   logic signed [X_W-1:0]      x_op;
   logic signed [B_W-1:0]      b_op;
   logic signed [PROD_W-1:0]   prod;
   logic signed [ACC_W-1:0]    p_ext;
   logic signed [ACC_W-1:0]    addend;
   logic signed [ACC_W-1:0]    rnd;
   logic signed [HROUND_W-1:0] h_round;

   // temperature term runs on (t - 2500), t = raw - 3965
   assign slope = signed'({1'b0, raw_temp}) - SLOPE_OFS;

   always_comb begin
      case (mac_ctl.x_sel)
         X_R:     x_op = signed'({{(X_W-WORD_W){1'b0}}, raw_hum});
         X_S:     x_op = {{(X_W-TEMP_W){slope[TEMP_W-1]}}, slope};
         X_RR:    x_op = signed'({{(X_W-RR_W){1'b0}}, rr_ff});
         X_RS:    x_op = {{(X_W-RS_W){rs_ff[RS_W-1]}}, rs_ff};
         default: x_op = '0;
      endcase
      case (mac_ctl.b_sel)
         B_R:     b_op = signed'({1'b0, raw_hum});
         B_K:     b_op = k_chunk(mac_ctl.kconst, mac_ctl.pos);
         default: b_op = '0;
      endcase
   end

   assign prod  = x_op * b_op;
   assign p_ext = {{(ACC_W-PROD_W){p_ff[PROD_W-1]}}, p_ff};

   // place the previous partial product at its chunk position
   always_comb begin
      case (pos_ff)
         2'd0:    addend = p_ext;
         2'd1:    addend = p_ext <<< CHUNK_W;
         default: addend = p_ext <<< (2 * CHUNK_W);
      endcase
      if (mac_ctl.init) begin
         acc_in = Q_C0;
      end else if (mac_ctl.add) begin
         acc_in = acc_ff + addend;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      case (mac_ctl.dest)
         MD_P: begin
            p_ff   <= prod;
            pos_ff <= mac_ctl.pos;
         end
         MD_RR:   rr_ff <= prod[RR_W-1:0];
         MD_RS:   rs_ff <= prod[RS_W-1:0];
         default: ;
      endcase
   end

   // round half up, then clamp to 16 bits
   assign rnd     = acc_ff + ROUND_HALF;
   assign h_round = rnd[ACC_W-1:FRAC_W];

   always_comb begin
      if (h_round > HUM_MAX) begin
         humidity = HUM_MAX[HUM_W-1:0];
      end else if (h_round < HUM_MIN) begin
         humidity = HUM_MIN[HUM_W-1:0];
      end else begin
         humidity = h_round[HUM_W-1:0];
      end
   end

endmodule
